// ----- hdl/c2d3_pkg.sv -----
// shared constants for the 3x3 saturating convolution stream
`default_nettype none
package c2d3_pkg;

  // default build sizes
  localparam int MAX_WIDTH_DEFAULT  = 256;
  localparam int PIXEL_BITS_DEFAULT = 8;

  // register port sizes
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 3;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_ROW0  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_ROW1  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_ROW2  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_STRIDE_H     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_STRIDE_V     = 3'd6;

  // register field widths
  localparam int WIDTH_REG_W  = 9;
  localparam int HEIGHT_REG_W = 11;
  localparam int KROW_W       = 24;
  localparam int STRIDE_W     = 3;
  localparam int WEIGHT_W     = 8;

  // register reset values
  localparam logic [WIDTH_REG_W-1:0]  IMAGE_WIDTH_RST  = 9'd62;
  localparam logic [HEIGHT_REG_W-1:0] IMAGE_HEIGHT_RST = 11'd12;
  localparam logic [KROW_W-1:0]       KERNEL_ROW_RST   = 24'h010001;
  localparam logic [STRIDE_W-1:0]     STRIDE_RST       = 3'd1;

  // frame geometry limits
  localparam int MIN_DIM    = 3;
  localparam int MAX_HEIGHT = 1024;
  localparam int ROW_W      = 10;
  localparam int HCMP_W     = 12;
  localparam int MAX_STRIDE = 4;
  localparam int PHASE_W    = 2;

  // result range
  localparam int OUT_W   = 8;
  localparam int SAT_MAX = 127;
  localparam int SAT_MIN = -128;

endpackage
`default_nettype wire

// ----- hdl/conv2d_3x3_saturating_stream.sv -----
// 3x3 sliding-window convolution over a raster pixel stream, saturated to 8 bits
// Pipeline registers in order: input stage, window, products, row sums, output.
// Throughput: one pixel per cycle when not stalled; line stores are read at the accept
// edge and written back at the next advance; one read and one write per column per pixel.
// Stalls on the master side hold the whole pipeline (s_tready follows the output register).
// Reset (rst, synchronous): registers to defaults, position and stride phases to zero,
// window to zero, pipeline empty; line store contents are left as they are.
`default_nettype none
module conv2d_3x3_saturating_stream #(
  parameter int MAX_WIDTH  = c2d3_pkg::MAX_WIDTH_DEFAULT,
  parameter int PIXEL_BITS = c2d3_pkg::PIXEL_BITS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // pixel input
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [((PIXEL_BITS+7)/8)*8-1:0]     s_tdata,   // [PIXEL_BITS-1:0] pixel
  // result output
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [7:0]                               m_tdata,   // [7:0] conv_value
  output logic                                     m_tlast,   // frame_last
  // register writes
  input  wire logic                                cfg_we,
  input  wire logic [c2d3_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [c2d3_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int CMP_W  = ((CW > c2d3_pkg::WIDTH_REG_W) ? CW : c2d3_pkg::WIDTH_REG_W) + 2;
  localparam int PROD_W = PIXEL_BITS + c2d3_pkg::WEIGHT_W;
  localparam int PART_W = PROD_W + 2;
  localparam int SUM_W  = PROD_W + 4;
  localparam int HW     = c2d3_pkg::HCMP_W;

  // configuration registers
  logic [c2d3_pkg::WIDTH_REG_W-1:0]  image_width;
  logic [c2d3_pkg::HEIGHT_REG_W-1:0] image_height;
  logic [c2d3_pkg::KROW_W-1:0]       kernel_row [3];
  logic [c2d3_pkg::STRIDE_W-1:0]     stride_h;
  logic [c2d3_pkg::STRIDE_W-1:0]     stride_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= c2d3_pkg::IMAGE_WIDTH_RST;
      image_height  <= c2d3_pkg::IMAGE_HEIGHT_RST;
      kernel_row[0] <= c2d3_pkg::KERNEL_ROW_RST;
      kernel_row[1] <= c2d3_pkg::KERNEL_ROW_RST;
      kernel_row[2] <= c2d3_pkg::KERNEL_ROW_RST;
      stride_h      <= c2d3_pkg::STRIDE_RST;
      stride_v      <= c2d3_pkg::STRIDE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        c2d3_pkg::REG_IMAGE_WIDTH:  image_width   <= cfg_data[c2d3_pkg::WIDTH_REG_W-1:0];
        c2d3_pkg::REG_IMAGE_HEIGHT: image_height  <= cfg_data[c2d3_pkg::HEIGHT_REG_W-1:0];
        c2d3_pkg::REG_KERNEL_ROW0:  kernel_row[0] <= cfg_data[c2d3_pkg::KROW_W-1:0];
        c2d3_pkg::REG_KERNEL_ROW1:  kernel_row[1] <= cfg_data[c2d3_pkg::KROW_W-1:0];
        c2d3_pkg::REG_KERNEL_ROW2:  kernel_row[2] <= cfg_data[c2d3_pkg::KROW_W-1:0];
        c2d3_pkg::REG_STRIDE_H:     stride_h      <= cfg_data[c2d3_pkg::STRIDE_W-1:0];
        c2d3_pkg::REG_STRIDE_V:     stride_v      <= cfg_data[c2d3_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  logic [CMP_W-1:0]              w_raw, w_eff, w_last;
  logic [HW-1:0]                 h_raw, h_eff, h_last;
  logic [c2d3_pkg::STRIDE_W-1:0] sh_eff, sv_eff;

  always_comb begin
    w_raw = CMP_W'(image_width);
    if (w_raw < CMP_W'(c2d3_pkg::MIN_DIM))    w_eff = CMP_W'(c2d3_pkg::MIN_DIM);
    else if (w_raw > CMP_W'(MAX_WIDTH))       w_eff = CMP_W'(MAX_WIDTH);
    else                                      w_eff = w_raw;
    w_last = w_eff - CMP_W'(1);
    h_raw = HW'(image_height);
    if (h_raw < HW'(c2d3_pkg::MIN_DIM))        h_eff = HW'(c2d3_pkg::MIN_DIM);
    else if (h_raw > HW'(c2d3_pkg::MAX_HEIGHT)) h_eff = HW'(c2d3_pkg::MAX_HEIGHT);
    else                                       h_eff = h_raw;
    h_last = h_eff - HW'(1);
    if (stride_h == '0) sh_eff = c2d3_pkg::STRIDE_W'(1);
    else if (stride_h > c2d3_pkg::STRIDE_W'(c2d3_pkg::MAX_STRIDE))
      sh_eff = c2d3_pkg::STRIDE_W'(c2d3_pkg::MAX_STRIDE);
    else sh_eff = stride_h;
    if (stride_v == '0) sv_eff = c2d3_pkg::STRIDE_W'(1);
    else if (stride_v > c2d3_pkg::STRIDE_W'(c2d3_pkg::MAX_STRIDE))
      sv_eff = c2d3_pkg::STRIDE_W'(c2d3_pkg::MAX_STRIDE);
    else sv_eff = stride_v;
  end

  // pipeline advance: the whole pipe moves when the output register can take data
  logic o_valid;
  logic adv;
  logic in_xfer;

  assign adv      = !o_valid || m_tready;
  assign s_tready = adv;
  assign in_xfer  = s_tvalid && adv;

  // raster position and stride phases
  logic [CW-1:0]                col, col_next;
  logic [c2d3_pkg::ROW_W-1:0]   row, row_next;
  logic [c2d3_pkg::PHASE_W-1:0] ph_h, ph_h_next, ph_v, ph_v_next;
  logic                         in_grid, emit, last, row_end, frame_end;
  logic [c2d3_pkg::STRIDE_W-1:0] ph_h_inc, ph_v_inc;

  always_comb begin
    in_grid   = (row >= c2d3_pkg::ROW_W'(2)) && (col >= CW'(2));
    emit      = in_grid && (ph_h == '0) && (ph_v == '0);
    last      = ((HW'(row) + HW'(sv_eff)) > h_last) &&
                ((CMP_W'(col) + CMP_W'(sh_eff)) > w_last);
    row_end   = CMP_W'(col) >= w_last;
    frame_end = HW'(row) >= h_last;
    ph_h_inc  = c2d3_pkg::STRIDE_W'(ph_h) + c2d3_pkg::STRIDE_W'(1);
    ph_v_inc  = c2d3_pkg::STRIDE_W'(ph_v) + c2d3_pkg::STRIDE_W'(1);

    ph_h_next = ph_h;
    if (in_grid) ph_h_next = (ph_h_inc >= sh_eff) ? '0 : c2d3_pkg::PHASE_W'(ph_h_inc);
    ph_v_next = ph_v;
    col_next  = col + CW'(1);
    row_next  = row;
    if (row_end) begin
      col_next  = '0;
      ph_h_next = '0;
      if (row >= c2d3_pkg::ROW_W'(2))
        ph_v_next = (ph_v_inc >= sv_eff) ? '0 : c2d3_pkg::PHASE_W'(ph_v_inc);
      if (frame_end) begin
        row_next  = '0;
        ph_v_next = '0;
      end else begin
        row_next = row + c2d3_pkg::ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      ph_h <= '0;
      ph_v <= '0;
    end else if (in_xfer) begin
      col  <= col_next;
      row  <= row_next;
      ph_h <= ph_h_next;
      ph_v <= ph_v_next;
    end
  end

  // line stores: read at the accept edge, written back at the next pipeline advance
  logic [PIXEL_BITS-1:0] line_upper [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] line_lower [MAX_WIDTH];
  logic                  b_valid, b_emit, b_last;
  logic [CW-1:0]         b_addr;
  logic [PIXEL_BITS-1:0] b_px, b_up, b_lo;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      b_up <= line_upper[col];
      b_lo <= line_lower[col];
    end
    if (b_valid && adv) begin
      line_upper[b_addr] <= b_lo;
      line_lower[b_addr] <= b_px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      b_addr <= col;
      b_px   <= s_tdata[PIXEL_BITS-1:0];
      b_emit <= emit;
      b_last <= last;
    end
  end

  // 3x3 window shift
  logic [PIXEL_BITS-1:0] win [9];
  logic                  w_valid, w_last_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) win[i] <= '0;
      w_valid <= 1'b0;
    end else if (adv) begin
      w_valid <= b_valid && b_emit;
      if (b_valid) begin
        for (int i = 0; i < 3; i++) begin
          win[i*3+0] <= win[i*3+1];
          win[i*3+1] <= win[i*3+2];
        end
        win[2] <= b_up;
        win[5] <= b_lo;
        win[8] <= b_px;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) w_last_q <= b_last;
  end

  // nine products in parallel
  logic signed [PROD_W-1:0] prod [9];
  logic                     p_valid, p_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= w_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_last <= w_last_q;
      for (int ki = 0; ki < 3; ki++) begin
        for (int kj = 0; kj < 3; kj++) begin
          prod[ki*3+kj] <= PROD_W'($signed(win[ki*3+kj]) *
                           $signed(kernel_row[ki][kj*c2d3_pkg::WEIGHT_W +: c2d3_pkg::WEIGHT_W]));
        end
      end
    end
  end

  // row partial sums
  logic signed [PART_W-1:0] part [3];
  logic                     s_valid, s_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (adv) begin
      s_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_last <= p_last;
      for (int ki = 0; ki < 3; ki++) begin
        part[ki] <= PART_W'(prod[ki*3]) + PART_W'(prod[ki*3+1]) + PART_W'(prod[ki*3+2]);
      end
    end
  end

  // final sum, saturation and output register
  logic signed [SUM_W-1:0] total;
  logic [7:0]              sat;

  always_comb begin
    total = SUM_W'(part[0]) + SUM_W'(part[1]) + SUM_W'(part[2]);
    if (total > SUM_W'(c2d3_pkg::SAT_MAX))      sat = 8'(c2d3_pkg::SAT_MAX);
    else if (total < SUM_W'(c2d3_pkg::SAT_MIN)) sat = 8'(c2d3_pkg::SAT_MIN);
    else                                        sat = total[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= sat;
      m_tlast <= s_last;
    end
  end

  assign m_tvalid = o_valid;

  // the pending write-back never targets the column being read
  assert property (@(posedge clk) disable iff (rst)
    (b_valid && in_xfer) |-> (col != b_addr))
    else $error("line store read and write-back hit the same column");

  // frame end returns position and phases to the origin
  assert property (@(posedge clk) disable iff (rst)
    (in_xfer && row_end && frame_end) |=>
      (col == '0 && row == '0 && ph_h == '0 && ph_v == '0))
    else $error("position not cleared at frame end");

  // results only come from full windows
  assert property (@(posedge clk) disable iff (rst)
    (in_xfer && emit) |-> (row >= c2d3_pkg::ROW_W'(2) && col >= CW'(2)))
    else $error("result requested before a full window");

  // a stall freezes the pipeline occupancy
  assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(b_valid) && $stable(w_valid) && $stable(p_valid) && $stable(s_valid)))
    else $error("pipeline moved during a stall");

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// self-checking bench for the 3x3 saturating convolution stream: directed frames, then random ones
module testbench;
  import c2d3_pkg::*;

  localparam int LINE_DEPTH    = MAX_WIDTH_DEFAULT;
  localparam int RANDOM_PIXELS = 830;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int MAX_GAP       = 12;
  localparam int DIRECTED_ROWS = 27;
  // index past the last register, writes to it must change nothing
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

  typedef enum logic [1:0] {ROW_WRITE, ROW_PIXEL, ROW_CHECKED} row_kind_e;
  typedef enum logic [1:0] {MIX_FULL, MIX_SMALL, MIX_EXTREME} value_mix_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [CFG_INDEX_W-1:0]  index;
    logic [CFG_DATA_W-1:0]   data;   // register value, or the pixel in the low byte
    logic [OUT_W-1:0]        value;
    logic                    last;
  } stim_row_t;

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             last;
  } conv_result_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata   = '0;   // [7:0] pixel
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [7:0]             m_tdata;          // [7:0] conv_value
  logic                   m_tlast;          // frame_last
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  always #10 clk = ~clk;

  conv2d_3x3_saturating_stream u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow registers and window state of the convolver
  logic [WIDTH_REG_W-1:0]  width_reg    = IMAGE_WIDTH_RST;
  logic [HEIGHT_REG_W-1:0] height_reg   = IMAGE_HEIGHT_RST;
  logic [KROW_W-1:0]       kernel_reg [3] = '{KERNEL_ROW_RST, KERNEL_ROW_RST, KERNEL_ROW_RST};
  logic [STRIDE_W-1:0]     stride_h_reg = STRIDE_RST;
  logic [STRIDE_W-1:0]     stride_v_reg = STRIDE_RST;
  logic [7:0]              upper_line [LINE_DEPTH] = '{default: '0};
  logic [7:0]              lower_line [LINE_DEPTH] = '{default: '0};
  bit                      upper_known [LINE_DEPTH];
  bit                      lower_known [LINE_DEPTH];
  logic [7:0]              window [9] = '{default: '0};
  int unsigned             col_pos = 0;
  int unsigned             row_pos = 0;
  int unsigned             phase_h = 0;
  int unsigned             phase_v = 0;

  conv_result_t queued_convs [$];
  int           fault_count     = 0;
  int           sender_idle_pct = 38;
  int           recv_idle_pct   = 62;

  // two small frames: default kernel's outer columns, then both weight extremes with saturation
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_WRITE,   REG_IMAGE_WIDTH,  24'd3,       8'h00, 1'b0},
    '{ROW_WRITE,   REG_IMAGE_HEIGHT, 24'd3,       8'h00, 1'b0},
    '{ROW_PIXEL,   REG_SPARE,        24'h00000A,  8'h00, 1'b0},
    '{ROW_PIXEL,   REG_SPARE,        24'h00007F,  8'h00, 1'b0},
    '{ROW_PIXEL,   REG_SPARE,        24'h000014,  8'h00, 1'b0},
    '{ROW_PIXEL,   REG_SPARE,        24'h00001E,  8'h00, 1'b0},
    '{ROW_PIXEL,   REG_SPARE,        24'h000080,  8'h00, 1'b0},
    '{ROW_PIXEL,   REG_SPARE,        24'h000028,  8'h00, 1'b0},
    '{ROW_PIXEL,   REG_SPARE,        24'h000032,  8'h00, 1'b0},
    '{ROW_PIXEL,   REG_SPARE,        24'h000000,  8'h00, 1'b0},
    '{ROW_CHECKED, REG_SPARE,        24'h0000C4,  8'h5A, 1'b1},
    '{ROW_WRITE,   REG_IMAGE_WIDTH,  24'd4,       8'h00, 1'b0},
    '{ROW_WRITE,   REG_KERNEL_ROW0,  24'h7F7F7F,  8'h00, 1'b0},
    '{ROW_WRITE,   REG_KERNEL_ROW1,  24'h808080,  8'h00, 1'b0},
    '{ROW_WRITE,   REG_KERNEL_ROW2,  24'h808080,  8'h00, 1'b0},
    '{ROW_PIXEL,   REG_SPARE,        24'h000080,  8'h00, 1'b0},
    '{ROW_PIXEL,   REG_SPARE,        24'h000000,  8'h00, 1'b0},
    '{ROW_PIXEL,   REG_SPARE,        24'h000000,  8'h00, 1'b0},
    '{ROW_PIXEL,   REG_SPARE,        24'h00007F,  8'h00, 1'b0},
    '{ROW_PIXEL,   REG_SPARE,        24'h000080,  8'h00, 1'b0},
    '{ROW_PIXEL,   REG_SPARE,        24'h000000,  8'h00, 1'b0},
    '{ROW_PIXEL,   REG_SPARE,        24'h000000,  8'h00, 1'b0},
    '{ROW_PIXEL,   REG_SPARE,        24'h00007F,  8'h00, 1'b0},
    '{ROW_PIXEL,   REG_SPARE,        24'h000080,  8'h00, 1'b0},
    '{ROW_PIXEL,   REG_SPARE,        24'h000000,  8'h00, 1'b0},
    '{ROW_CHECKED, REG_SPARE,        24'h000000,  8'h7F, 1'b0},
    '{ROW_CHECKED, REG_SPARE,        24'h00007F,  8'h80, 1'b1}
  };

  function automatic int unsigned clamp_range(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int unsigned line_length(logic [WIDTH_REG_W-1:0] v);
    return clamp_range(v, MIN_DIM, LINE_DEPTH);
  endfunction

  function automatic int unsigned frame_rows();
    return clamp_range(height_reg, MIN_DIM, MAX_HEIGHT);
  endfunction

  function automatic int unsigned next_phase(int unsigned phase, int unsigned stride);
    return (phase + 1 >= stride) ? 0 : phase + 1;
  endfunction

  // leading columns whose upper and lower line entries both hold written pixels
  function automatic int unsigned known_columns();
    int unsigned n;
    n = 0;
    while (n < LINE_DEPTH && upper_known[n]) n++;
    return n;
  endfunction

  // shift one pixel into the window; returns 1 when a stride-aligned sum comes out
  function automatic bit window_conv_step(input logic [7:0] px, output conv_result_t res);
    int unsigned w, h, sh, sv, c, r;
    logic [7:0]  up, lo;
    int          sum, a, b, i, j;
    bit          fire;
    w    = line_length(width_reg);
    h    = frame_rows();
    sh   = clamp_range(stride_h_reg, 1, MAX_STRIDE);
    sv   = clamp_range(stride_v_reg, 1, MAX_STRIDE);
    c    = col_pos;
    r    = row_pos;
    fire = 1'b0;
    res  = '0;
    // line stores: lower row moves up, new pixel enters below
    up = upper_line[c];
    lo = lower_line[c];
    upper_line[c]  = lo;
    lower_line[c]  = px;
    upper_known[c] = lower_known[c];
    lower_known[c] = 1'b1;
    for (i = 0; i < 3; i++) begin
      window[i*3]   = window[i*3+1];
      window[i*3+1] = window[i*3+2];
    end
    window[2] = up;
    window[5] = lo;
    window[8] = px;
    // full window on the stride grid
    if (r >= 2 && c >= 2) begin
      if (phase_v == 0 && phase_h == 0) begin
        sum = 0;
        for (i = 0; i < 3; i++) begin
          for (j = 0; j < 3; j++) begin
            a = $signed(window[i*3+j]);
            b = $signed(kernel_reg[i][j*8 +: 8]);
            sum += a * b;
          end
        end
        if (sum > SAT_MAX) sum = SAT_MAX;
        else if (sum < SAT_MIN) sum = SAT_MIN;
        res.value = sum[OUT_W-1:0];
        res.last  = (r + sv > h - 1) && (c + sh > w - 1);
        fire      = 1'b1;
      end
      phase_h = next_phase(phase_h, sh);
    end
    // raster position, row and frame wrap
    if (c >= w - 1) begin
      col_pos = 0;
      phase_h = 0;
      if (r >= 2) phase_v = next_phase(phase_v, sv);
      if (r >= h - 1) begin
        row_pos = 0;
        phase_v = 0;
      end else begin
        row_pos = r + 1;
      end
    end else begin
      col_pos = c + 1;
    end
    return fire;
  endfunction

  function automatic logic [7:0] pick_byte(value_mix_e mix);
    case (mix)
      MIX_SMALL: return 8'($urandom_range(8) - 4);
      MIX_EXTREME: begin
        case ($urandom_range(4))
          0: return 8'h80;
          1: return 8'h81;
          2: return 8'h7F;
          3: return 8'hFF;
          default: return 8'h00;
        endcase
      end
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [WIDTH_REG_W-1:0] pick_width();
    case ($urandom_range(19))
      0:       return WIDTH_REG_W'($urandom_range(2));
      1:       return WIDTH_REG_W'($urandom_range(511, 257));
      2:       return WIDTH_REG_W'(LINE_DEPTH);
      3, 4, 5: return WIDTH_REG_W'($urandom_range(40, 11));
      default: return WIDTH_REG_W'($urandom_range(10, 3));
    endcase
  endfunction

  function automatic logic [HEIGHT_REG_W-1:0] pick_height();
    case ($urandom_range(19))
      0:       return HEIGHT_REG_W'($urandom_range(2));
      1:       return HEIGHT_REG_W'($urandom_range(2047, 1025));
      2:       return HEIGHT_REG_W'(MAX_HEIGHT);
      3, 4:    return HEIGHT_REG_W'($urandom_range(20, 7));
      default: return HEIGHT_REG_W'($urandom_range(6, 3));
    endcase
  endfunction

  function automatic logic [STRIDE_W-1:0] pick_stride();
    return $urandom_range(1) ? STRIDE_RST : STRIDE_W'($urandom_range(7));
  endfunction

  function automatic logic [KROW_W-1:0] pick_kernel_row(value_mix_e mix);
    return {pick_byte(mix), pick_byte(mix), pick_byte(mix)};
  endfunction

  // one register transfer; cfg_we stays high until the caller lowers it
  task automatic reg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:  width_reg     = d[WIDTH_REG_W-1:0];
      REG_IMAGE_HEIGHT: height_reg    = d[HEIGHT_REG_W-1:0];
      REG_KERNEL_ROW0:  kernel_reg[0] = d[KROW_W-1:0];
      REG_KERNEL_ROW1:  kernel_reg[1] = d[KROW_W-1:0];
      REG_KERNEL_ROW2:  kernel_reg[2] = d[KROW_W-1:0];
      REG_STRIDE_H:     stride_h_reg  = d[STRIDE_W-1:0];
      REG_STRIDE_V:     stride_v_reg  = d[STRIDE_W-1:0];
      default: ;
    endcase
  endtask

  // hold the input until every pending sum is out and the pipe has flushed
  task automatic wait_drained();
    int waited, settled;
    waited  = 0;
    settled = 0;
    s_tvalid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (queued_convs.size() != 0 && waited < DRAIN_LIMIT);
    while (settled < SETTLE_CYCLES) begin
      @(posedge clk);
      if (m_tready) settled++;
    end
  endtask

  // pixel transfer with a random lead-in gap; typed rows replace the computed sum
  task automatic send_pixel(input logic [7:0] px, input bit typed, input conv_result_t typed_res);
    conv_result_t res;
    bit           fired;
    int           gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    do @(posedge clk); while (!s_tready);
    fired = window_conv_step(px, res);
    if (typed) queued_convs.push_back(typed_res);
    else if (fired) queued_convs.push_back(res);
  endtask

  // new settings between bursts, often in mid-frame
  task automatic retune(input bit every_reg);
    value_mix_e              kmix;
    logic [WIDTH_REG_W-1:0]  w;
    wait_drained();
    kmix = value_mix_e'($urandom_range(2));
    if (every_reg || $urandom_range(1)) begin
      w = pick_width();
      // widening in mid-frame only over columns that hold written pixels
      if ((col_pos != 0 || row_pos != 0) && line_length(w) > line_length(width_reg) &&
          known_columns() < line_length(w))
        w = width_reg;
      reg_write(REG_IMAGE_WIDTH, {(CFG_DATA_W-WIDTH_REG_W)'($urandom()), w});
    end
    if (every_reg || $urandom_range(1))
      reg_write(REG_IMAGE_HEIGHT, {(CFG_DATA_W-HEIGHT_REG_W)'($urandom()), pick_height()});
    if (every_reg || $urandom_range(1)) reg_write(REG_KERNEL_ROW0, pick_kernel_row(kmix));
    if (every_reg || $urandom_range(1)) reg_write(REG_KERNEL_ROW1, pick_kernel_row(kmix));
    if (every_reg || $urandom_range(1)) reg_write(REG_KERNEL_ROW2, pick_kernel_row(kmix));
    if (every_reg || $urandom_range(1))
      reg_write(REG_STRIDE_H, {(CFG_DATA_W-STRIDE_W)'($urandom()), pick_stride()});
    if (every_reg || $urandom_range(1))
      reg_write(REG_STRIDE_V, {(CFG_DATA_W-STRIDE_W)'($urandom()), pick_stride()});
    if ($urandom_range(7) == 0) reg_write(REG_SPARE, CFG_DATA_W'($urandom()));
    cfg_we <= 1'b0;
  endtask

  // result side: random stalls and in-order comparison
  always @(posedge clk) begin
    conv_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (queued_convs.size() == 0) begin
          $display("%0t: result with none pending: expected nothing, got value %0d last %0b",
                   $time, $signed(m_tdata), m_tlast);
          fault_count++;
        end else begin
          want = queued_convs.pop_front();
          if (m_tdata !== want.value) begin
            $display("%0t: conv_value expected %0d, got %0d",
                     $time, $signed(want.value), $signed(m_tdata));
            fault_count++;
          end
          if (m_tlast !== want.last) begin
            $display("%0t: frame_last expected %0b, got %0b", $time, want.last, m_tlast);
            fault_count++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // stimulus
  initial begin
    stim_row_t  row;
    value_mix_e pmix;
    int         burst, remaining, pixels_sent;
    bit         first;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed table, register transfers grouped while idle
    for (int n = 0; n < DIRECTED_ROWS; n++) begin
      row = directed_rows[n];
      if (row.kind == ROW_WRITE) begin
        if (n == 0 || directed_rows[n-1].kind != ROW_WRITE) wait_drained();
        reg_write(row.index, row.data);
        if (n + 1 == DIRECTED_ROWS || directed_rows[n+1].kind != ROW_WRITE) cfg_we <= 1'b0;
      end else begin
        send_pixel(row.data[7:0], row.kind == ROW_CHECKED,
                   conv_result_t'{row.value, row.last});
      end
    end

    // random bursts: mostly whole small frames, some cut off in mid-frame
    pixels_sent = 0;
    first       = 1'b1;
    while (pixels_sent < RANDOM_PIXELS) begin
      if (pixels_sent >= 2 * RANDOM_PIXELS / 3) begin
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
      end else if (pixels_sent >= RANDOM_PIXELS / 3) begin
        sender_idle_pct = 62;
        recv_idle_pct   = 38;
      end
      retune(first);
      first = 1'b0;
      case ($urandom_range(9))
        0, 1:    pmix = MIX_SMALL;
        2:       pmix = MIX_EXTREME;
        default: pmix = MIX_FULL;
      endcase
      remaining = int'(frame_rows()) - int'(row_pos);
      remaining = remaining * int'(line_length(width_reg)) - int'(col_pos);
      if (remaining > 0 && remaining <= 160 && $urandom_range(3) != 0) burst = remaining;
      else burst = $urandom_range(120, 8);
      repeat (burst) send_pixel(pick_byte(pmix), 1'b0, '0);
      pixels_sent += burst;
    end

    wait_drained();
    if (queued_convs.size() != 0) begin
      $display("%0t: %0d sums never came out, first expected value %0d last %0b, got none",
               $time, queued_convs.size(), $signed(queued_convs[0].value),
               queued_convs[0].last);
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- conv2d_3x3_saturating_stream.f -----
hdl/c2d3_pkg.sv
hdl/conv2d_3x3_saturating_stream.sv
sim/testbench.sv
